[rtl/source_tokenizer_macros.svh]
// Assertion macros for the source tokenizer.
// Used by the top level; no other dependencies.
`ifndef SOURCE_TOKENIZER_MACROS_SVH
`define SOURCE_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
`define ST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define ST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/st_pkg.sv]
// Shared types and constants of the source tokenizer: token word, kind codes,
// character codes and the keyword table. No dependencies.
`default_nettype none
package st_pkg;

    localparam int COUNTER_BITS_DEF  = 16;
    localparam int KEYWORD_CHARS_DEF = 6;
    localparam int STRING_MAX_DEF    = 254;
    localparam int OUTQ_DEPTH        = 4;

    // token kinds
    localparam logic [4:0] K_NUMBER = 5'd0;
    localparam logic [4:0] K_IDENT  = 5'd1;
    localparam logic [4:0] K_STRING = 5'd2;
    localparam logic [4:0] K_FN     = 5'd3;
    localparam logic [4:0] K_INT    = 5'd4;
    localparam logic [4:0] K_IF     = 5'd5;
    localparam logic [4:0] K_RETURN = 5'd6;
    localparam logic [4:0] K_LET    = 5'd7;
    localparam logic [4:0] K_I32    = 5'd8;
    localparam logic [4:0] K_I8     = 5'd9;
    localparam logic [4:0] K_I16    = 5'd10;
    localparam logic [4:0] K_I64    = 5'd11;
    localparam logic [4:0] K_U8     = 5'd12;
    localparam logic [4:0] K_U16    = 5'd13;
    localparam logic [4:0] K_U32    = 5'd14;
    localparam logic [4:0] K_U64    = 5'd15;
    localparam logic [4:0] K_VOID   = 5'd16;
    localparam logic [4:0] K_EXTRN  = 5'd17;
    localparam logic [4:0] K_PLUS   = 5'd18;
    localparam logic [4:0] K_INC    = 5'd19;
    localparam logic [4:0] K_MINUS  = 5'd20;
    localparam logic [4:0] K_DEC    = 5'd21;
    localparam logic [4:0] K_STAR   = 5'd22;
    localparam logic [4:0] K_SLASH  = 5'd23;
    localparam logic [4:0] K_LPAREN = 5'd24;
    localparam logic [4:0] K_RPAREN = 5'd25;
    localparam logic [4:0] K_COLON  = 5'd26;
    localparam logic [4:0] K_SEMI   = 5'd27;
    localparam logic [4:0] K_LBRACE = 5'd28;
    localparam logic [4:0] K_RBRACE = 5'd29;
    localparam logic [4:0] K_ASSIGN = 5'd30;
    localparam logic [4:0] K_EOF    = 5'd31;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_ASSIGN = 8'h3d;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    // keyword text, right-justified, first character in the high byte
    localparam logic [47:0] KW_TEXT [16] = '{
        48'("fn"), 48'("int"), 48'("if"), 48'("str"), 48'("return"), 48'("let"),
        48'("i32"), 48'("i8"), 48'("i16"), 48'("i64"), 48'("u8"), 48'("u16"),
        48'("u32"), 48'("u64"), 48'("void"), 48'("extrn")
    };
    localparam logic [3:0] KW_LEN [16] = '{
        4'd2, 4'd3, 4'd2, 4'd3, 4'd6, 4'd3, 4'd3, 4'd2,
        4'd3, 4'd3, 4'd2, 4'd3, 4'd3, 4'd3, 4'd4, 4'd5
    };
    localparam logic [4:0] KW_KIND [16] = '{
        K_FN, K_INT, K_IF, K_STRING, K_RETURN, K_LET, K_I32, K_I8,
        K_I16, K_I64, K_U8, K_U16, K_U32, K_U64, K_VOID, K_EXTRN
    };

    // one result word; kind sits in the lowest bits
    typedef struct packed {
        logic        last;
        logic [15:0] len;
        logic [15:0] off;
        logic [15:0] ecol;
        logic [15:0] scol;
        logic [15:0] line;
        logic [4:0]  kind;
    } t_token;

    function automatic logic [4:0] kw_lookup(input logic [47:0] text, input logic [3:0] len);
        logic [4:0] kind;
        kind = K_IDENT;
        for (int i = 0; i < 16; i++) begin
            if (len == KW_LEN[i] && text == KW_TEXT[i]) begin
                kind = KW_KIND[i];
            end
        end
        return kind;
    endfunction

endpackage
`default_nettype wire

[rtl/source_tokenizer.sv]
// Top level of the source tokenizer: scanner state, token formation and the
// stream ports. Depends on st_pkg, st_outq and source_tokenizer_macros.svh.
//
//  port group | dir | word                         | accepted when
//  s_axis_*   | in  | tdata: char_code; tlast: eoi | s_axis_tvalid & s_axis_tready
//  m_axis_*   | out | tdata: token fields; tlast   | m_axis_tvalid & m_axis_tready
//
// One source byte is taken per cycle while s_axis_tready is high; its tokens are
// formed in the same cycle and written into a four-entry result queue, which
// registers them. A byte yields zero, one or two tokens; tokens leave at one per
// cycle while m_axis_tready is high, so a run of two-token bytes is paced by the
// queue's output port. s_axis_tready is high while the queue has two free entries.
// Reset is synchronous and active low; no clearing pass is needed.
`default_nettype none
`include "source_tokenizer_macros.svh"
module source_tokenizer import st_pkg::*; #(
    parameter int COUNTER_BITS  = COUNTER_BITS_DEF,
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
    parameter int STRING_MAX    = STRING_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] char_code
    input  wire logic        s_axis_tlast,  // end_of_input
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [4:0] token_kind, [20:5] token_line, [36:21] start_column,
    // [52:37] end_column, [68:53] start_offset, [84:69] text_length, [87:85] zero
    output logic [87:0]      m_axis_tdata,
    output logic             m_axis_tlast   // last_of_run
);
    localparam int CB    = COUNTER_BITS;
    localparam int SM_W  = $clog2(STRING_MAX + 1);
    localparam int LEN_W = (CB > SM_W) ? CB : SM_W;
    localparam int PW    = 8 * KEYWORD_CHARS;
    localparam logic [LEN_W-1:0] LEN_CNT_MAX = LEN_W'((64'd1 << CB) - 64'd1);

    typedef enum logic [2:0] {
        M_IDLE, M_NUMBER, M_WORD, M_STRING, M_PLUS, M_MINUS, M_SLASH, M_COMMENT
    } t_mode;

    t_mode              r_mode,  n_mode;
    logic [CB-1:0]      r_line,  n_line;
    logic [CB-1:0]      r_col,   n_col;
    logic [CB-1:0]      r_off,   n_off;
    logic [CB-1:0]      r_tline, n_tline;
    logic [CB-1:0]      r_tcol,  n_tcol;
    logic [CB-1:0]      r_toff,  n_toff;
    logic [LEN_W-1:0]   r_tlen,  n_tlen;
    logic [PW-1:0]      r_prefix, n_prefix;

    logic               in_acc;
    logic [7:0]         c;
    logic               eoi;
    logic               is_dig, is_let;
    logic [CB-1:0]      here;
    logic [4:0]         word_kind;
    logic               close_v, start_v, do_start;
    t_token             close_t, start_t;
    t_token             word0, word1;
    logic [1:0]         push;
    logic               q_room;
    t_token             q_word;

    function automatic logic [CB-1:0] sat_cb(input logic [CB-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
        return (v >= LEN_CNT_MAX) ? LEN_CNT_MAX : v + 1'b1;
    endfunction

    function automatic t_token tok(input logic [4:0] k, input logic [CB-1:0] ln,
                                   input logic [CB-1:0] sc, input logic [CB-1:0] ec,
                                   input logic [CB-1:0] of, input logic [LEN_W-1:0] le);
        t_token t;
        t.kind = k;
        t.line = 16'(ln);
        t.scol = 16'(sc);
        t.ecol = 16'(ec);
        t.off  = 16'(of);
        t.len  = 16'(le);
        t.last = 1'b0;
        return t;
    endfunction

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign c      = s_axis_tdata;
    assign eoi    = s_axis_tlast || (c == CH_NUL);
    assign is_dig = (c >= 8'h30) && (c <= 8'h39);
    assign is_let = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    assign here   = r_col - 1'b1;

    // longer words never match; a shorter one holds exactly its own bytes
    assign word_kind = (r_tlen > LEN_W'(KEYWORD_CHARS)) ? K_IDENT
                     : kw_lookup(48'(r_prefix), 4'(r_tlen));

    always_comb begin
        n_mode   = r_mode;
        n_line   = r_line;
        n_col    = r_col;
        n_off    = r_off;
        n_tline  = r_tline;
        n_tcol   = r_tcol;
        n_toff   = r_toff;
        n_tlen   = r_tlen;
        n_prefix = r_prefix;
        close_v  = 1'b0;
        close_t  = '0;
        start_v  = 1'b0;
        start_t  = '0;
        do_start = 1'b0;
        if (eoi) begin
            close_v = 1'b1;
            unique case (r_mode)
                M_NUMBER: close_t = tok(K_NUMBER, r_tline, r_tcol, here, r_toff, r_tlen);
                M_WORD:   close_t = tok(word_kind, r_tline, r_tcol, here, r_toff, r_tlen);
                M_STRING: close_t = tok(K_STRING, r_tline, r_tcol, here, r_toff, r_tlen);
                M_PLUS:   close_t = tok(K_PLUS, r_tline, r_tcol, r_tcol, r_toff, LEN_W'(1));
                M_MINUS:  close_t = tok(K_MINUS, r_tline, r_tcol, r_tcol, r_toff, LEN_W'(1));
                M_SLASH:  close_t = tok(K_SLASH, r_tline, r_tcol, r_tcol, r_toff, LEN_W'(1));
                default:  close_v = 1'b0;
            endcase
            start_v  = 1'b1;
            start_t  = tok(K_EOF, r_line, here, here, r_off, '0);
            // back to reset for the next stream
            n_mode   = M_IDLE;
            n_line   = CB'(1);
            n_col    = CB'(1);
            n_off    = '0;
            n_tline  = '0;
            n_tcol   = '0;
            n_toff   = '0;
            n_tlen   = '0;
            n_prefix = '0;
        end else begin
            unique case (r_mode)
                M_NUMBER: begin
                    if (is_dig) begin
                        n_tlen = sat_len(r_tlen);
                    end else begin
                        close_v  = 1'b1;
                        close_t  = tok(K_NUMBER, r_tline, r_tcol, here, r_toff, r_tlen);
                        do_start = 1'b1;
                    end
                end
                M_WORD: begin
                    if (is_dig || is_let || c == CH_UNDER) begin
                        if (r_tlen < LEN_W'(KEYWORD_CHARS)) begin
                            n_prefix = {r_prefix[PW-9:0], c};
                        end
                        n_tlen = sat_len(r_tlen);
                    end else begin
                        close_v  = 1'b1;
                        close_t  = tok(word_kind, r_tline, r_tcol, here, r_toff, r_tlen);
                        do_start = 1'b1;
                    end
                end
                M_STRING: begin
                    if (c == CH_QUOTE) begin
                        close_v = 1'b1;
                        close_t = tok(K_STRING, r_tline, r_tcol, r_col, r_toff, r_tlen);
                        n_mode  = M_IDLE;
                    end else if (r_tlen < LEN_W'(STRING_MAX)) begin
                        n_tlen = r_tlen + 1'b1;
                    end
                end
                M_PLUS, M_MINUS: begin
                    close_v = 1'b1;
                    if (c == ((r_mode == M_PLUS) ? CH_PLUS : CH_MINUS)) begin
                        close_t = tok((r_mode == M_PLUS) ? K_INC : K_DEC,
                                      r_tline, r_tcol, r_col, r_toff, LEN_W'(2));
                        n_mode  = M_IDLE;
                    end else begin
                        close_t  = tok((r_mode == M_PLUS) ? K_PLUS : K_MINUS,
                                       r_tline, r_tcol, r_tcol, r_toff, LEN_W'(1));
                        do_start = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (c == CH_SLASH) begin
                        n_mode = M_COMMENT;
                    end else begin
                        close_v  = 1'b1;
                        close_t  = tok(K_SLASH, r_tline, r_tcol, r_tcol, r_toff, LEN_W'(1));
                        do_start = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (c == CH_NL) begin
                        n_mode = M_IDLE;
                    end
                end
                M_IDLE: do_start = 1'b1;
            endcase

            if (do_start) begin
                n_tline = r_line;
                n_tcol  = here;
                n_toff  = r_off;
                n_tlen  = LEN_W'(1);
                n_mode  = M_IDLE;
                start_t = tok(K_STAR, r_line, here, here, r_off, LEN_W'(1));
                if (is_dig) begin
                    n_mode = M_NUMBER;
                end else if (is_let) begin
                    n_mode   = M_WORD;
                    n_prefix = PW'(c);
                end else begin
                    // anything unlisted is dropped
                    unique case (c)
                        CH_QUOTE: begin
                            n_mode = M_STRING;
                            n_tlen = '0;
                        end
                        CH_PLUS:   n_mode = M_PLUS;
                        CH_MINUS:  n_mode = M_MINUS;
                        CH_SLASH:  n_mode = M_SLASH;
                        CH_STAR:   start_v = 1'b1;
                        CH_LPAREN: begin start_v = 1'b1; start_t.kind = K_LPAREN; end
                        CH_RPAREN: begin start_v = 1'b1; start_t.kind = K_RPAREN; end
                        CH_COLON:  begin start_v = 1'b1; start_t.kind = K_COLON;  end
                        CH_SEMI:   begin start_v = 1'b1; start_t.kind = K_SEMI;   end
                        CH_LBRACE: begin start_v = 1'b1; start_t.kind = K_LBRACE; end
                        CH_RBRACE: begin start_v = 1'b1; start_t.kind = K_RBRACE; end
                        CH_ASSIGN: begin start_v = 1'b1; start_t.kind = K_ASSIGN; end
                        default:   ;
                    endcase
                end
            end

            if (c == CH_NL) begin
                n_line = sat_cb(r_line);
                n_col  = CB'(1);
            end else begin
                n_col  = sat_cb(r_col);
            end
            n_off = sat_cb(r_off);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_line   <= CB'(1);
            r_col    <= CB'(1);
            r_off    <= '0;
            r_tline  <= '0;
            r_tcol   <= '0;
            r_toff   <= '0;
            r_tlen   <= '0;
            r_prefix <= '0;
        end else if (in_acc) begin
            r_mode   <= n_mode;
            r_line   <= n_line;
            r_col    <= n_col;
            r_off    <= n_off;
            r_tline  <= n_tline;
            r_tcol   <= n_tcol;
            r_toff   <= n_toff;
            r_tlen   <= n_tlen;
            r_prefix <= n_prefix;
        end
    end

    // pack the pending token ahead of the new one; flag the final word
    always_comb begin
        word0      = close_v ? close_t : start_t;
        word0.last = !(close_v && start_v);
        word1      = start_t;
        word1.last = 1'b1;
        push       = in_acc ? (2'(close_v) + 2'(start_v)) : 2'd0;
    end

    st_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_word0  (word0),
        .i_word1  (word1),
        .o_room   (q_room),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_word   (q_word)
    );

    assign s_axis_tready = q_room;
    assign m_axis_tdata  = {3'b000, q_word.len, q_word.off, q_word.ecol,
                            q_word.scol, q_word.line, q_word.kind};
    assign m_axis_tlast  = q_word.last;

    `ST_ASSERT_NXT(a_eoi_resets, i_clk, i_rst_n, in_acc && eoi, r_mode == M_IDLE && r_line == CB'(1) && r_col == CB'(1) && r_off == '0, "state not cleared after end of input")
    `ST_ASSERT_NXT(a_eoi_emits, i_clk, i_rst_n, in_acc && eoi, m_axis_tvalid, "no token after end of input")
    `ST_ASSERT_NXT(a_newline_col, i_clk, i_rst_n, in_acc && !eoi && c == CH_NL, r_col == CB'(1), "column not restarted on newline")
    `ST_ASSERT_IMP(a_string_len, i_clk, i_rst_n, r_mode == M_STRING, r_tlen <= LEN_W'(STRING_MAX), "string length past its limit")

endmodule
`default_nettype wire

[rtl/st_outq.sv]
// Result queue of the source tokenizer: takes up to two token words a cycle,
// hands out one a cycle on the master stream while i_tready is high. Uses st_pkg.
`default_nettype none
module st_outq import st_pkg::*; #(
    parameter int DEPTH = OUTQ_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_push,
    input  wire t_token     i_word0,
    input  wire t_token     i_word1,
    output logic            o_room,
    output logic            o_tvalid,
    input  wire logic       i_tready,
    output t_token          o_word
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_token             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]   wr1;
    logic               pop;

    function automatic logic [PTR_W-1:0] step(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr1 = step(r_wr);
    assign pop = (r_cnt != '0) && i_tready;

    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wr] <= i_word0;
        end
        if (i_push == 2'd2) begin
            r_mem[wr1] <= i_word1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            unique case (i_push)
                2'd0:    r_wr <= r_wr;
                2'd1:    r_wr <= wr1;
                default: r_wr <= step(wr1);
            endcase
            if (pop) begin
                r_rd <= step(r_rd);
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(pop);
        end
    end

    // room for the worst case of two words from one input byte
    assign o_room   = (r_cnt <= CNT_W'(DEPTH - 2));
    assign o_tvalid = (r_cnt != '0);
    assign o_word   = r_mem[r_rd];

endmodule
`default_nettype wire

[dv/source_tokenizer_checker.sv]
`timescale 1ns / 1ps
// Token scoreboard for the source tokenizer: predicts the tokens of every byte word
// taken on the input channel and compares the words leaving the output channel.
// Depends on st_pkg for the token word type, kind codes and character codes.
module source_tokenizer_checker import st_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_byte_valid,
    input  logic        i_byte_ready,
    input  logic [7:0]  i_byte_data,    // [7:0] char_code
    input  logic        i_byte_end,     // end_of_input
    input  logic        i_token_valid,
    input  logic        i_token_ready,
    // [4:0] kind, [20:5] line, [36:21] start col, [52:37] end col,
    // [68:53] offset, [84:69] length
    input  logic [87:0] i_token_data,
    input  logic        i_token_last,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    localparam int unsigned CNT_MAX       = 65535;
    localparam int unsigned KEYWORD_LIMIT = 6;
    localparam int unsigned STRING_LIMIT  = 254;

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_NUMBER, SCAN_WORD, SCAN_STRING,
        SCAN_PLUS, SCAN_MINUS, SCAN_SLASH, SCAN_COMMENT
    } t_scan_mode;

    t_scan_mode  mode;
    int unsigned line_no, col_no, offset;
    int unsigned tok_line, tok_col, tok_off, tok_len;
    logic [47:0] prefix;
    int          emitted;
    t_token      token_q[$];

    int errors  = 0;
    int pending = 0;
    int checked = 0;

    assign o_errors  = errors;
    assign o_pending = pending;
    assign o_checked = checked;

    function automatic int unsigned bump(input int unsigned v);
        return (v >= CNT_MAX) ? CNT_MAX : v + 1;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // prefix holds every character of a word of at most KEYWORD_LIMIT, so equal
    // text means equal length
    function automatic logic [4:0] keyword_kind(input int unsigned len,
                                                input logic [47:0] text);
        if (len > KEYWORD_LIMIT) return K_IDENT;
        case (text)
            48'("fn"):     return K_FN;
            48'("int"):    return K_INT;
            48'("if"):     return K_IF;
            48'("str"):    return K_STRING;
            48'("return"): return K_RETURN;
            48'("let"):    return K_LET;
            48'("i32"):    return K_I32;
            48'("i8"):     return K_I8;
            48'("i16"):    return K_I16;
            48'("i64"):    return K_I64;
            48'("u8"):     return K_U8;
            48'("u16"):    return K_U16;
            48'("u32"):    return K_U32;
            48'("u64"):    return K_U64;
            48'("void"):   return K_VOID;
            48'("extrn"):  return K_EXTRN;
            default:       return K_IDENT;
        endcase
    endfunction

    task automatic restart_scan();
        mode     = SCAN_IDLE;
        line_no  = 1;
        col_no   = 1;
        offset   = 0;
        tok_line = 0;
        tok_col  = 0;
        tok_off  = 0;
        tok_len  = 0;
        prefix   = '0;
    endtask

    task automatic add_token(input logic [4:0] kind, input int unsigned line,
                             input int unsigned scol, input int unsigned ecol,
                             input int unsigned off, input int unsigned len);
        t_token t;
        t.kind = kind;
        t.line = 16'(line);
        t.scol = 16'(scol);
        t.ecol = 16'(ecol);
        t.off  = 16'(off);
        t.len  = 16'(len);
        t.last = 1'b0;
        token_q.push_back(t);
        emitted++;
    endtask

    task automatic close_token(input logic [4:0] kind, input int unsigned ecol,
                               input int unsigned len);
        add_token(kind, tok_line, tok_col, ecol, tok_off, len);
    endtask

    task automatic flag_last();
        t_token t;
        t = token_q.pop_back();
        t.last = 1'b1;
        token_q.push_back(t);
    endtask

    // start a token at the current position; single-character operators other than +, - and / go out at once
    task automatic open_token(input logic [7:0] c);
        tok_line = line_no;
        tok_col  = col_no - 1;
        tok_off  = offset;
        tok_len  = 1;
        mode     = SCAN_IDLE;
        if (is_digit(c)) begin
            mode = SCAN_NUMBER;
        end else if (is_letter(c)) begin
            mode   = SCAN_WORD;
            prefix = {40'd0, c};
        end else begin
            case (c)
                CH_QUOTE: begin
                    mode    = SCAN_STRING;
                    tok_len = 0;
                end
                CH_PLUS:   mode = SCAN_PLUS;
                CH_MINUS:  mode = SCAN_MINUS;
                CH_SLASH:  mode = SCAN_SLASH;
                CH_STAR:   add_token(K_STAR, line_no, tok_col, tok_col, offset, 1);
                CH_LPAREN: add_token(K_LPAREN, line_no, tok_col, tok_col, offset, 1);
                CH_RPAREN: add_token(K_RPAREN, line_no, tok_col, tok_col, offset, 1);
                CH_COLON:  add_token(K_COLON, line_no, tok_col, tok_col, offset, 1);
                CH_SEMI:   add_token(K_SEMI, line_no, tok_col, tok_col, offset, 1);
                CH_LBRACE: add_token(K_LBRACE, line_no, tok_col, tok_col, offset, 1);
                CH_RBRACE: add_token(K_RBRACE, line_no, tok_col, tok_col, offset, 1);
                CH_ASSIGN: add_token(K_ASSIGN, line_no, tok_col, tok_col, offset, 1);
                default: ;
            endcase
        end
    endtask

    task automatic scan_byte(input logic [7:0] c, input logic eoi);
        int unsigned here;
        here    = col_no - 1;
        emitted = 0;
        if (eoi || c == CH_NUL) begin
            // flush the pending token, drop a pending comment, then end of file
            case (mode)
                SCAN_NUMBER: close_token(K_NUMBER, here, tok_len);
                SCAN_WORD:   close_token(keyword_kind(tok_len, prefix), here, tok_len);
                SCAN_STRING: close_token(K_STRING, here, tok_len);
                SCAN_PLUS:   close_token(K_PLUS, tok_col, 1);
                SCAN_MINUS:  close_token(K_MINUS, tok_col, 1);
                SCAN_SLASH:  close_token(K_SLASH, tok_col, 1);
                default: ;
            endcase
            add_token(K_EOF, line_no, here, here, offset, 0);
            flag_last();
            restart_scan();
        end else begin
            case (mode)
                SCAN_NUMBER: begin
                    if (is_digit(c)) begin
                        tok_len = bump(tok_len);
                    end else begin
                        close_token(K_NUMBER, here, tok_len);
                        open_token(c);
                    end
                end
                SCAN_WORD: begin
                    if (is_digit(c) || is_letter(c) || c == CH_UNDER) begin
                        if (tok_len < KEYWORD_LIMIT) prefix = {prefix[39:0], c};
                        tok_len = bump(tok_len);
                    end else begin
                        close_token(keyword_kind(tok_len, prefix), here, tok_len);
                        open_token(c);
                    end
                end
                SCAN_STRING: begin
                    if (c == CH_QUOTE) begin
                        close_token(K_STRING, col_no, tok_len);
                        mode = SCAN_IDLE;
                    end else if (tok_len < STRING_LIMIT) begin
                        tok_len++;
                    end
                end
                SCAN_PLUS: begin
                    if (c == CH_PLUS) begin
                        close_token(K_INC, col_no, 2);
                        mode = SCAN_IDLE;
                    end else begin
                        close_token(K_PLUS, tok_col, 1);
                        open_token(c);
                    end
                end
                SCAN_MINUS: begin
                    if (c == CH_MINUS) begin
                        close_token(K_DEC, col_no, 2);
                        mode = SCAN_IDLE;
                    end else begin
                        close_token(K_MINUS, tok_col, 1);
                        open_token(c);
                    end
                end
                SCAN_SLASH: begin
                    if (c == CH_SLASH) begin
                        mode = SCAN_COMMENT;
                    end else begin
                        close_token(K_SLASH, tok_col, 1);
                        open_token(c);
                    end
                end
                SCAN_COMMENT: begin
                    if (c == CH_NL) mode = SCAN_IDLE;
                end
                default: open_token(c);
            endcase
            if (c == CH_NL) begin
                line_no = bump(line_no);
                col_no  = 1;
            end else begin
                col_no = bump(col_no);
            end
            offset = bump(offset);
            if (emitted > 0) flag_last();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_token want;
        if (!i_rst_n) begin
            restart_scan();
            token_q.delete();
        end else begin
            if (i_byte_valid && i_byte_ready) scan_byte(i_byte_data, i_byte_end);
            if (i_token_valid && i_token_ready) begin
                if (token_q.size() == 0) begin
                    $error("token word with none expected: data %h, last %b",
                           i_token_data, i_token_last);
                    errors++;
                end else begin
                    want = token_q.pop_front();
                    check_field("token_kind", want.kind, i_token_data[4:0]);
                    check_field("token_line", want.line, i_token_data[20:5]);
                    check_field("start_column", want.scol, i_token_data[36:21]);
                    check_field("end_column", want.ecol, i_token_data[52:37]);
                    check_field("start_offset", want.off, i_token_data[68:53]);
                    check_field("text_length", want.len, i_token_data[84:69]);
                    check_field("last_of_run", want.last, i_token_last);
                    checked++;
                end
            end
        end
        pending = token_q.size();
    end

endmodule

[dv/source_tokenizer_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the source tokenizer: clock, reset, byte stimulus in random
// bursts, a stalling token receiver and the verdict. Depends on st_pkg,
// source_tokenizer and source_tokenizer_checker.
module source_tokenizer_tb;
    import st_pkg::*;

    localparam int RANDOM_BYTES = 1350;
    localparam int LONG_HOLD    = 300;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;     // [7:0] char_code
    logic        s_axis_tlast  = 1'b0;   // end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;           // [4:0] kind .. [84:69] length, see block
    logic        m_axis_tlast;           // last_of_run

    int errors, pending, checked;
    int hold_req   = 0;
    int holds_done = 0;
    int burst_max  = 12;
    int gap_max    = 4;
    int burst_left = 0;
    int bytes_sent = 0;
    int streams    = 0;

    string kw_words [16] = '{"fn", "int", "if", "str", "return", "let", "i32", "i8",
                             "i16", "i64", "u8", "u16", "u32", "u64", "void", "extrn"};
    string near_words [8] = '{"i128", "returns", "u", "ex", "voids", "Fn", "lets", "i6"};
    string op_words [15] = '{"+", "++", "-", "--", "*", "/", "(", ")", ":", ";",
                             "{", "}", "=", "+++", "-+"};

    source_tokenizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    source_tokenizer_checker token_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_valid  (s_axis_tvalid),
        .i_byte_ready  (s_axis_tready),
        .i_byte_data   (s_axis_tdata),
        .i_byte_end    (s_axis_tlast),
        .i_token_valid (m_axis_tvalid),
        .i_token_ready (m_axis_tready),
        .i_token_data  (m_axis_tdata),
        .i_token_last  (m_axis_tlast),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("timeout: tokenizer stopped making progress");
        $display("source_tokenizer test failed");
        $finish;
    end

    // token receiver: stall patterns of random length, plus long holds on request
    initial begin
        int pattern;
        forever begin
            if (hold_req != holds_done) begin
                @(negedge i_clk) m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                holds_done++;
            end else begin
                pattern = $urandom_range(0, 3);
                repeat ($urandom_range(4, 40)) begin
                    @(negedge i_clk);
                    case (pattern)
                        0: m_axis_tready <= 1'b1;
                        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                        2: m_axis_tready <= ($urandom_range(0, 1) != 0);
                        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                    endcase
                end
            end
        end
    end

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'(r) + "a" : 8'(r - 26) + "A";
    endfunction

    function automatic logic [7:0] rand_word_char();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(0, 9)) + "0";
            1: return CH_UNDER;
            default: return rand_letter();
        endcase
    endfunction

    // offer one byte word after the burst's gap, hold it until taken
    task automatic put(input logic [7:0] c, input logic eoi);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                @(negedge i_clk) s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eoi;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put(s[i], 1'b0);
    endtask

    task automatic drain();
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        burst_left = 0;
    endtask

    // one lexeme with random content, then an optional random separator
    task automatic put_lexeme();
        int pick, n;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            put_text(kw_words[$urandom_range(0, 15)]);
        end else if (pick < 22) begin
            put_text(near_words[$urandom_range(0, 7)]);
        end else if (pick < 40) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            put(rand_letter(), 1'b0);
            repeat (n - 1) put(rand_word_char(), 1'b0);
        end else if (pick < 52) begin
            repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 9)) + "0", 1'b0);
        end else if (pick < 60) begin
            n = ($urandom_range(0, 29) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 8);
            put(CH_QUOTE, 1'b0);
            repeat (n) begin
                c = ($urandom_range(0, 9) == 0) ? CH_NL : 8'($urandom_range(32, 255));
                put((c == CH_QUOTE) ? CH_UNDER : c, 1'b0);
            end
            put(CH_QUOTE, 1'b0);
        end else if (pick < 88) begin
            put_text(op_words[$urandom_range(0, 14)]);
        end else if (pick < 92) begin
            put_text("//");
            repeat ($urandom_range(0, 6)) put(8'($urandom_range(32, 255)), 1'b0);
            put(CH_NL, 1'b0);
        end else begin
            put(8'($urandom_range(1, 255)), 1'b0);
        end
        case ($urandom_range(0, 5))
            0, 1: ;
            2, 3: put(" ", 1'b0);
            4:    put(CH_NL, 1'b0);
            default: put(($urandom_range(0, 1) != 0) ? 8'h09 : 8'h0d, 1'b0);
        endcase
    endtask

    // close a stream in one of the ways the block accepts
    task automatic end_stream();
        case ($urandom_range(0, 5))
            0: put(CH_NUL, 1'b0);
            1: put(8'($urandom_range(1, 255)), 1'b1);
            2: put(CH_NUL, 1'b1);
            3: begin
                put(CH_QUOTE, 1'b0);
                put_text("ab\n");
                put(8'($urandom_range(0, 255)), 1'b1);
            end
            4: begin
                put_text("//z");
                put(CH_NUL, 1'b0);
            end
            default: begin
                put(CH_SLASH, 1'b0);
                put(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
        streams++;
    endtask

    task automatic random_stream();
        if ($urandom_range(0, 9) == 0) begin
            // raw noise, may end the stream on its own
            repeat ($urandom_range(4, 30))
                put(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end else begin
            repeat ($urandom_range(1, 40)) put_lexeme();
        end
        end_stream();
    endtask

    initial begin
        int goal;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every operator, two-token bytes, skipped bytes, a newline in an open string
        put_text("++--+-*/:;(){}=_");
        put(8'hff, 1'b0);
        put_text("\"a\n");
        put("z", 1'b1);
        put_text("//x");
        put(CH_NUL, 1'b0);
        streams += 2;
        drain();

        goal = bytes_sent + RANDOM_BYTES;
        hold_req++;
        while (bytes_sent < goal) begin
            if (hold_req == holds_done && bytes_sent > goal - RANDOM_BYTES / 2
                && hold_req < 2) begin
                hold_req++;
            end
            random_stream();
            if ($urandom_range(0, 7) == 0) drain();
        end
        drain();

        repeat (5) random_stream();
        drain();
        repeat (20) @(negedge i_clk);

        $display("covered %0d bytes in %0d streams, %0d tokens compared,", bytes_sent,
                 streams, checked);
        $display("including keywords, operators, comments, long strings and receiver holds");
        if (errors == 0 && pending == 0) begin
            $display("source_tokenizer test passed");
        end else begin
            $display("source_tokenizer test failed");
        end
        $finish;
    end

endmodule
